### rtl/core/qrat_pkg.sv
// Shared types, codes and defaults for the quorum read ack tracker.
package qrat_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int MAX_PEERS_DEF   = 8;

	localparam int TAG_W  = 16;
	localparam int NODE_W = 4;
	localparam int PEER_W = 3;
	localparam int NEED_W = 3;
	localparam int PCNT_W = 5;

	localparam logic [NODE_W-1:0] NODE_COUNT_RST = 4'd3;
	localparam logic [NODE_W-1:0] NODE_COUNT_ONE = 4'd1;

	typedef logic [TAG_W-1:0]  tag_t;
	typedef logic [NODE_W-1:0] node_count_t;
	typedef logic [PCNT_W-1:0] pcount_t;
	typedef logic [NEED_W-1:0] need_t;

	// Input item codes
	localparam logic [1:0] MODE_ISSUE  = 2'd0;
	localparam logic [1:0] MODE_ACK    = 2'd1;
	localparam logic [1:0] MODE_CANCEL = 2'd2;
	localparam logic [1:0] MODE_QUERY  = 2'd3;

	// Result kinds
	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_DONE   = 2'd1;
	localparam logic [1:0] KIND_COUNT  = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_STOPPED    = 2'd1;
	localparam logic [1:0] ST_NOT_LEADER = 2'd2;
	localparam logic [1:0] ST_FULL       = 2'd3;

	typedef struct packed {
		logic [1:0]        mode;
		logic              node_running;
		logic              node_is_leader;
		tag_t              request_tag;
		logic [PEER_W-1:0] ack_peer;
	} req_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] status;
		tag_t       tag;
		pcount_t    pending_count;
		logic       last;
	} rsp_t;

	function automatic rsp_t mk_rsp(logic [1:0] kind, logic [1:0] status, tag_t tag,
			pcount_t pcnt);
		rsp_t r;
		r.kind          = kind;
		r.status        = status;
		r.tag           = tag;
		r.pending_count = pcnt;
		r.last          = 1'b0;
		return r;
	endfunction

endpackage

### rtl/core/qrat_ifs.sv
// Valid/ready channel interfaces for requests, results and the configuration write.
interface qrat_req_if;
	logic              valid;
	logic              ready;
	qrat_pkg::req_t    data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface qrat_rsp_if;
	logic              valid;
	logic              ready;
	qrat_pkg::rsp_t    data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface qrat_cfg_if;
	logic                  valid;
	logic                  ready;
	qrat_pkg::node_count_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/qrat_ram.sv
// Generic single-write, single-read RAM with registered read data.
module qrat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/core/qrat_upd.sv
// Shared entry update unit: merge an ack into one entry and test its quorum.
module qrat_upd #(
	parameter int MAX_PEERS = qrat_pkg::MAX_PEERS_DEF
) (
	input  logic                           is_cancel,
	input  logic [MAX_PEERS-1:0]           ack_bit,
	input  logic [MAX_PEERS-1:0]           map_in,
	input  logic [$clog2(MAX_PEERS+1)-1:0] total_in,
	input  qrat_pkg::need_t                need_in,
	output logic [MAX_PEERS-1:0]           map_out,
	output logic [$clog2(MAX_PEERS+1)-1:0] total_out,
	output logic                           complete
);

	localparam int TW = $clog2(MAX_PEERS+1);
	localparam int CW = (TW > qrat_pkg::NEED_W) ? TW : qrat_pkg::NEED_W;

	logic         seen;
	logic [CW-1:0] total_ext;
	logic [CW-1:0] need_ext;

	always_comb begin
		seen      = |(map_in & ack_bit);
		map_out   = map_in | ack_bit;
		total_out = seen ? total_in : total_in + TW'(1);
		total_ext = CW'(total_out);
		need_ext  = CW'(need_in);
		// cancel retires every entry regardless of acks
		complete  = is_cancel | (total_ext >= need_ext);
	end

endmodule

### rtl/core/quorum_read_ack_tracker.sv
// Top level of the quorum read ack tracker: sequencer, entry RAM and result register.
// Issue and query: the result passes through the hold and output registers; the next item
//   is taken once the result is pushed; a single-node issue gives two results.
// Ack and cancel: each pending entry is read and then processed, one at a time, through the
//   single read port of the entry RAM; a dropped ack gives no result. Not ready meanwhile.
// Reset clears the sequencer and pending count and loads node_count 3; RAM is not cleared.
module quorum_read_ack_tracker #(
	parameter int TABLE_DEPTH = qrat_pkg::TABLE_DEPTH_DEF,
	parameter int MAX_PEERS   = qrat_pkg::MAX_PEERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	qrat_req_if.sink    req,
	qrat_rsp_if.source  rsp,
	qrat_cfg_if.sink    cfg
);

	localparam int AW    = $clog2(TABLE_DEPTH);
	localparam int CW    = $clog2(TABLE_DEPTH+1);
	localparam int TW    = $clog2(MAX_PEERS+1);
	localparam int NW    = qrat_pkg::NEED_W;
	localparam int TAGW  = qrat_pkg::TAG_W;
	localparam int EW    = TAGW + MAX_PEERS + TW + NW;
	// entry layout in the RAM: {tag, ack map, ack total, need}
	localparam int NEED_LO  = 0;
	localparam int TOT_LO   = NW;
	localparam int MAP_LO   = NW + TW;
	localparam int TAG_LO   = NW + TW + MAX_PEERS;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_ISSUE2 = 5'b00010,
		S_RD     = 5'b00100,
		S_PROC   = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

	state_t                   state_q, state_d;
	qrat_pkg::node_count_t    node_count_q;
	logic [CW-1:0]            count_q, count_d;
	logic [AW-1:0]            idx_q, idx_d;
	logic [CW-1:0]            wr_q, wr_d;
	logic                     cancel_q, cancel_d;
	logic [MAX_PEERS-1:0]     bit_q, bit_d;
	qrat_pkg::rsp_t           hold_q, hold_d;
	logic                     hold_vld_q, hold_vld_d;
	qrat_pkg::rsp_t           out_q;
	logic                     out_vld_q;

	logic                     in_xfer;
	logic                     can_push;
	logic                     push;
	qrat_pkg::rsp_t           push_data;
	logic [MAX_PEERS-1:0]     from_bit;
	logic                     ack_ok;

	// RAM ports
	logic                     ram_we;
	logic [AW-1:0]            ram_waddr;
	logic [EW-1:0]            ram_wdata;
	logic                     ram_re;
	logic [EW-1:0]            ram_rdata;

	// update unit
	logic [MAX_PEERS-1:0]     upd_map;
	logic [TW-1:0]            upd_total;
	logic                     upd_complete;
	logic                     last_entry;

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_vld_q;
	assign rsp.data  = out_q;

	assign in_xfer  = req.valid & req.ready;
	// output register is free, or empties this cycle
	assign can_push = ~out_vld_q | rsp.ready;

	always_comb begin
		for (int i = 0; i < MAX_PEERS; i++) begin
			from_bit[i] = (int'(req.data.ack_peer) == i);
		end
		ack_ok = req.data.node_is_leader
			& ({1'b0, req.data.ack_peer} < node_count_q)
			& (int'(req.data.ack_peer) < MAX_PEERS);
	end

	qrat_ram #(
		.WIDTH (EW),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	qrat_upd #(
		.MAX_PEERS (MAX_PEERS)
	) u_upd (
		.is_cancel (cancel_q),
		.ack_bit   (bit_q),
		.map_in    (ram_rdata[MAP_LO +: MAX_PEERS]),
		.total_in  (ram_rdata[TOT_LO +: TW]),
		.need_in   (ram_rdata[NEED_LO +: NW]),
		.map_out   (upd_map),
		.total_out (upd_total),
		.complete  (upd_complete)
	);

	assign last_entry = (CW'(idx_q) == (count_q - CW'(1)));

	// Sequencer: take an item, walk the pending entries in arrival order, compact the
	// survivors towards the head, and keep one completion back so that the final one
	// can be marked last.
	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		idx_d      = idx_q;
		wr_d       = wr_q;
		cancel_d   = cancel_q;
		bit_d      = bit_q;
		hold_d     = hold_q;
		hold_vld_d = hold_vld_q;
		push       = 1'b0;
		push_data  = hold_q;
		ram_we     = 1'b0;
		ram_waddr  = wr_q[AW-1:0];
		ram_wdata  = {ram_rdata[TAG_LO +: TAGW], upd_map, upd_total,
			ram_rdata[NEED_LO +: NW]};
		ram_re     = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					idx_d    = '0;
					wr_d     = '0;
					bit_d    = from_bit;
					cancel_d = (req.data.mode == qrat_pkg::MODE_CANCEL);
					case (req.data.mode)
						qrat_pkg::MODE_ISSUE: begin
							hold_vld_d = 1'b1;
							state_d    = S_DONE;
							if (!req.data.node_running) begin
								hold_d = qrat_pkg::mk_rsp(qrat_pkg::KIND_STATUS,
									qrat_pkg::ST_STOPPED, '0, '0);
							end else if (!req.data.node_is_leader) begin
								hold_d = qrat_pkg::mk_rsp(qrat_pkg::KIND_STATUS,
									qrat_pkg::ST_NOT_LEADER, '0, '0);
							end else if (node_count_q == qrat_pkg::NODE_COUNT_ONE) begin
								// single node: complete at once, status follows
								hold_d  = qrat_pkg::mk_rsp(qrat_pkg::KIND_DONE,
									qrat_pkg::ST_OK, req.data.request_tag, '0);
								state_d = S_ISSUE2;
							end else if (count_q == CW'(TABLE_DEPTH)) begin
								hold_d = qrat_pkg::mk_rsp(qrat_pkg::KIND_STATUS,
									qrat_pkg::ST_FULL, '0, '0);
							end else begin
								hold_d    = qrat_pkg::mk_rsp(qrat_pkg::KIND_STATUS,
									qrat_pkg::ST_OK, '0, '0);
								ram_we    = 1'b1;
								ram_waddr = count_q[AW-1:0];
								ram_wdata = {req.data.request_tag, {MAX_PEERS{1'b0}},
									{TW{1'b0}}, node_count_q[qrat_pkg::NODE_W-1:1]};
								count_d   = count_q + CW'(1);
							end
						end
						qrat_pkg::MODE_ACK: begin
							if (ack_ok && (count_q != '0)) begin
								state_d = S_RD;
							end
						end
						qrat_pkg::MODE_CANCEL: begin
							if (count_q != '0) begin
								state_d = S_RD;
							end
						end
						default: begin
							hold_d     = qrat_pkg::mk_rsp(qrat_pkg::KIND_COUNT,
								qrat_pkg::ST_OK, '0, qrat_pkg::pcount_t'(count_q));
							hold_vld_d = 1'b1;
							state_d    = S_DONE;
						end
					endcase
				end
			end
			S_ISSUE2: begin
				if (can_push) begin
					push    = 1'b1;
					hold_d  = qrat_pkg::mk_rsp(qrat_pkg::KIND_STATUS, qrat_pkg::ST_OK,
						'0, '0);
					state_d = S_DONE;
				end
			end
			S_RD: begin
				ram_re  = 1'b1;
				state_d = S_PROC;
			end
			S_PROC: begin
				if (!(upd_complete && hold_vld_q && !can_push)) begin
					if (upd_complete) begin
						push       = hold_vld_q;
						hold_d     = qrat_pkg::mk_rsp(qrat_pkg::KIND_DONE,
							cancel_q ? qrat_pkg::ST_NOT_LEADER : qrat_pkg::ST_OK,
							ram_rdata[TAG_LO +: TAGW], '0);
						hold_vld_d = 1'b1;
					end else begin
						// keep the entry: write it back at the compacted position
						ram_we = 1'b1;
						wr_d   = wr_q + CW'(1);
					end
					if (last_entry) begin
						count_d = upd_complete ? wr_q : wr_q + CW'(1);
						state_d = S_DONE;
					end else begin
						idx_d   = idx_q + AW'(1);
						state_d = S_RD;
					end
				end
			end
			S_DONE: begin
				if (!hold_vld_q) begin
					state_d = S_IDLE;
				end else if (can_push) begin
					push           = 1'b1;
					push_data.last = 1'b1;
					hold_vld_d     = 1'b0;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			node_count_q <= qrat_pkg::NODE_COUNT_RST;
			count_q      <= '0;
			hold_vld_q   <= 1'b0;
			out_vld_q    <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			hold_vld_q <= hold_vld_d;
			if (cfg.valid) begin
				node_count_q <= cfg.data;
			end
			// advance the output register, drop it once transferred
			if (push) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload: no reset needed
	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		wr_q     <= wr_d;
		cancel_q <= cancel_d;
		bit_q    <= bit_d;
		hold_q   <= hold_d;
		if (push) begin
			out_q <= push_data;
		end
	end

endmodule

### rtl/core/qrat_chk.sv
// Port-level assertions for the quorum read ack tracker, bound to the top level.
module qrat_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input qrat_pkg::rsp_t rsp_data
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");

	a_tag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.kind != qrat_pkg::KIND_DONE) |-> (rsp_data.tag == '0))
		else $error("tag set on a result that is not a completion");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.kind == qrat_pkg::KIND_STATUS) |-> rsp_data.last)
		else $error("issue status not marked last");

	a_count_form: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.kind == qrat_pkg::KIND_COUNT)
		|-> rsp_data.last && (rsp_data.status == qrat_pkg::ST_OK))
		else $error("pending count result malformed");

endmodule

bind quorum_read_ack_tracker qrat_chk u_qrat_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

### verif/quorum_read_ack_tracker_tb.sv
// Self-checking testbench for the quorum read ack tracker: directed and random transfers.
module quorum_read_ack_tracker_tb;

	// Table and peer limits as built into the block under test
	localparam int TABLE = qrat_pkg::TABLE_DEPTH_DEF;
	localparam int PEERS = qrat_pkg::MAX_PEERS_DEF;
	// Worst case for an ack or cancel to sweep the table with no output stall, plus margin
	localparam int SETTLE = 2 * TABLE + 8;
	localparam int CALM_TAIL = 60;
	localparam int HOLD_AT = 45;
	localparam int HOLD_CYCLES = 250;
	localparam int PHASES = 9;
	localparam int PHASE_ITEMS = 46;
	// Cluster sizes per random phase, the extremes and the zero size among them
	localparam int PHASE_NODES [PHASES] = '{8, 1, 0, 2, 15, 5, 8, 4, 3};
	// Share of well-formed issues per phase; the rest is mostly acks
	localparam int PHASE_ISSUE [PHASES] = '{60, 40, 50, 35, 40, 45, 30, 45, 40};

	typedef struct {
		bit                    is_setting;
		qrat_pkg::node_count_t nodes;
		qrat_pkg::req_t        item;
	} stim_t;

	logic clk;
	logic arst_n;

	qrat_req_if req_bus();
	qrat_rsp_if rsp_bus();
	qrat_cfg_if cfg_bus();

	quorum_read_ack_tracker DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus),
		.cfg    (cfg_bus)
	);

	// Pending transfers and configuration writes, in order of issue
	stim_t stim_q[$];
	// Results still owed by the block, oldest first
	qrat_pkg::rsp_t outcome_q[$];
	int mismatches = 0;

	// Shadow of the tracker state
	qrat_pkg::node_count_t cluster_nodes;
	logic                  slot_live [TABLE];
	qrat_pkg::tag_t        slot_read_tag [TABLE];
	logic [7:0]            slot_peers [TABLE];
	int unsigned           slot_acks [TABLE];
	int unsigned           slot_quorum [TABLE];
	int                    arrival_q[$];
	qrat_pkg::rsp_t        staged;
	bit                    staged_ok;

	// Driver and receiver bookkeeping
	int  gap_left = 0;
	int  since_req = 0;
	bit  stim_done = 1'b0;
	bit  calm = 1'b0;
	int  stall_left = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	int  hold_seen = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void queue_item(logic [1:0] mode, logic run, logic lead,
			qrat_pkg::tag_t tag, logic [qrat_pkg::PEER_W-1:0] peer);
		stim_t s;
		s.is_setting          = 1'b0;
		s.nodes               = '0;
		s.item.mode           = mode;
		s.item.node_running   = run;
		s.item.node_is_leader = lead;
		s.item.request_tag    = tag;
		s.item.ack_peer       = peer;
		stim_q.push_back(s);
	endfunction

	function automatic void queue_setting(qrat_pkg::node_count_t n);
		stim_t s;
		s.is_setting = 1'b1;
		s.nodes      = n;
		s.item       = '0;
		stim_q.push_back(s);
	endfunction

	// Hold back one result so that the last of a batch can be marked
	function automatic void stage_outcome(logic [1:0] kind, logic [1:0] status,
			qrat_pkg::tag_t tag, qrat_pkg::pcount_t count);
		if (staged_ok)
			outcome_q.push_back(staged);
		staged.kind          = kind;
		staged.status        = status;
		staged.tag           = tag;
		staged.pending_count = count;
		staged.last          = 1'b0;
		staged_ok            = 1'b1;
	endfunction

	// Work out every result one accepted transfer causes and queue them
	function automatic void predict_read_outcomes(qrat_pkg::req_t it);
		logic [1:0] st;
		int         slot;
		int         keep_q[$];
		staged_ok = 1'b0;
		case (it.mode)
			qrat_pkg::MODE_ISSUE: begin
				st = qrat_pkg::ST_OK;
				if (!it.node_running) begin
					st = qrat_pkg::ST_STOPPED;
				end else if (!it.node_is_leader) begin
					st = qrat_pkg::ST_NOT_LEADER;
				end else if (cluster_nodes == qrat_pkg::NODE_COUNT_ONE) begin
					// single node: done at once, even with a full table
					stage_outcome(qrat_pkg::KIND_DONE, qrat_pkg::ST_OK, it.request_tag, '0);
				end else if (arrival_q.size() >= TABLE) begin
					st = qrat_pkg::ST_FULL;
				end else begin
					slot = 0;
					while (slot_live[slot])
						slot++;
					slot_live[slot]     = 1'b1;
					slot_read_tag[slot] = it.request_tag;
					slot_peers[slot]    = '0;
					slot_acks[slot]     = 0;
					slot_quorum[slot]   = cluster_nodes / 2;
					arrival_q.push_back(slot);
				end
				stage_outcome(qrat_pkg::KIND_STATUS, st, '0, '0);
			end
			qrat_pkg::MODE_ACK: begin
				// drop acks from peers outside the cluster or while not leader
				if (it.ack_peer < cluster_nodes && it.ack_peer < PEERS &&
						it.node_is_leader) begin
					foreach (arrival_q[i]) begin
						slot = arrival_q[i];
						if (!slot_peers[slot][it.ack_peer]) begin
							slot_peers[slot][it.ack_peer] = 1'b1;
							slot_acks[slot]++;
						end
						if (slot_acks[slot] >= slot_quorum[slot]) begin
							slot_live[slot] = 1'b0;
							stage_outcome(qrat_pkg::KIND_DONE, qrat_pkg::ST_OK,
								slot_read_tag[slot], '0);
						end else begin
							keep_q.push_back(slot);
						end
					end
					arrival_q = keep_q;
				end
			end
			qrat_pkg::MODE_CANCEL: begin
				foreach (arrival_q[i]) begin
					slot_live[arrival_q[i]] = 1'b0;
					stage_outcome(qrat_pkg::KIND_DONE, qrat_pkg::ST_NOT_LEADER,
						slot_read_tag[arrival_q[i]], '0);
				end
				arrival_q.delete();
			end
			default: begin
				stage_outcome(qrat_pkg::KIND_COUNT, qrat_pkg::ST_OK, '0,
					qrat_pkg::pcount_t'(arrival_q.size()));
			end
		endcase
		if (staged_ok) begin
			staged.last = 1'b1;
			outcome_q.push_back(staged);
		end
	endfunction

	// Compare one result transfer with the oldest owed result
	function automatic void compare_outcome(qrat_pkg::rsp_t got);
		qrat_pkg::rsp_t want;
		if (outcome_q.size() == 0) begin
			if (mismatches < 10)
				$display("unexpected result at %0t: kind=%0d status=%0d tag=%h count=%0d last=%0d",
					$realtime, got.kind, got.status, got.tag, got.pending_count,
					got.last);
			mismatches++;
		end else begin
			want = outcome_q.pop_front();
			if (got.kind !== want.kind || got.status !== want.status || got.tag !== want.tag ||
					got.pending_count !== want.pending_count || got.last !== want.last) begin
				if (mismatches < 10) begin
					$display("result mismatch at %0t:", $realtime);
					$display("  expected kind=%0d status=%0d tag=%h count=%0d last=%0d",
						want.kind, want.status, want.tag, want.pending_count, want.last);
					$display("  got      kind=%0d status=%0d tag=%h count=%0d last=%0d",
						got.kind, got.status, got.tag, got.pending_count, got.last);
				end
				mismatches++;
			end
		end
	endfunction

	task automatic build_stimulus();
		int roll;
		int peer_top;
		// Directed part, at the reset cluster size of three (one ack completes)
		queue_item(qrat_pkg::MODE_QUERY, 1'b1, 1'b1, 16'h0000, 3'd0);  // empty table
		queue_item(qrat_pkg::MODE_ACK, 1'b1, 1'b1, 16'h0000, 3'd0);    // nothing pending
		queue_item(qrat_pkg::MODE_CANCEL, 1'b1, 1'b1, 16'h0000, 3'd0); // nothing pending
		queue_item(qrat_pkg::MODE_ISSUE, 1'b0, 1'b1, 16'hFFFF, 3'd7);  // stopped
		queue_item(qrat_pkg::MODE_ISSUE, 1'b1, 1'b0, 16'hFFFF, 3'd7);  // not leader
		queue_item(qrat_pkg::MODE_ISSUE, 1'b0, 1'b0, 16'h5A5A, 3'd0);  // stopped wins
		queue_item(qrat_pkg::MODE_ISSUE, 1'b1, 1'b1, 16'h0000, 3'd0);
		queue_item(qrat_pkg::MODE_ISSUE, 1'b1, 1'b1, 16'hFFFF, 3'd7);
		queue_item(qrat_pkg::MODE_QUERY, 1'b0, 1'b0, 16'hFFFF, 3'd7);
		queue_item(qrat_pkg::MODE_ACK, 1'b1, 1'b1, 16'h0000, 3'd3);    // peer outside cluster
		queue_item(qrat_pkg::MODE_ACK, 1'b1, 1'b1, 16'h0000, 3'd7);
		queue_item(qrat_pkg::MODE_ACK, 1'b1, 1'b0, 16'h0000, 3'd1);    // acks need leadership
		queue_item(qrat_pkg::MODE_ACK, 1'b0, 1'b1, 16'hFFFF, 3'd2);    // both reads complete
		queue_item(qrat_pkg::MODE_ISSUE, 1'b1, 1'b1, 16'h1234, 3'd5);
		queue_item(qrat_pkg::MODE_ISSUE, 1'b1, 1'b1, 16'hA5A5, 3'd2);
		queue_item(qrat_pkg::MODE_CANCEL, 1'b0, 1'b0, 16'hFFFF, 3'd7);
		queue_item(qrat_pkg::MODE_QUERY, 1'b1, 1'b1, 16'h0000, 3'd0);
		// Random phases: mostly well-formed traffic, some noise
		for (int p = 0; p < PHASES; p++) begin
			queue_setting(qrat_pkg::node_count_t'(PHASE_NODES[p]));
			peer_top = (PHASE_NODES[p] == 0 || PHASE_NODES[p] > PEERS) ? PEERS - 1 :
				PHASE_NODES[p] - 1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				roll = $urandom_range(0, 99);
				if (roll < 8)
					queue_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
						3'($urandom_range(0, 7)));
				else if (roll < 14)
					queue_item(qrat_pkg::MODE_QUERY, 1'b1, 1'b1,
						16'($urandom_range(0, 65535)), 3'($urandom_range(0, 7)));
				else if (roll < 18)
					queue_item(qrat_pkg::MODE_CANCEL, 1'b1, 1'b1,
						16'($urandom_range(0, 65535)), 3'($urandom_range(0, 7)));
				else if (roll < 18 + PHASE_ISSUE[p])
					queue_item(qrat_pkg::MODE_ISSUE, 1'b1, 1'b1,
						16'($urandom_range(0, 65535)), 3'($urandom_range(0, 7)));
				else
					queue_item(qrat_pkg::MODE_ACK, 1'b1, 1'b1,
						16'($urandom_range(0, 65535)), 3'($urandom_range(0, peer_top)));
			end
		end
	endtask

	// Reset, stimulus and end of run
	initial begin
		arst_n        = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.data  = '0;
		rsp_bus.ready = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.data  = '0;
		build_stimulus();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// wait for the driver to empty its queue, then for every owed result
		while (!stim_done)
			@(posedge clk);
		while (outcome_q.size() > 0)
			@(posedge clk);
		// allow stray results from the last sweep to show up
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && outcome_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Hard limit, several times the slowest correct run
	initial begin
		#1000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Driver: offer queued transfers with random gaps; write the register only once idle
	always @(posedge clk) begin
		logic nxt_req;
		logic nxt_cfg;
		nxt_req = req_bus.valid;
		nxt_cfg = cfg_bus.valid;
		if (arst_n) begin
			since_req++;
			if (req_bus.valid && req_bus.ready) begin
				nxt_req   = 1'b0;
				since_req = 0;
			end
			if (cfg_bus.valid && cfg_bus.ready)
				nxt_cfg = 1'b0;
			if (!nxt_req && !nxt_cfg) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (stim_q.size() > 0) begin
					if (stim_q[0].is_setting) begin
						// hold the write until the block has swept its last transfer
						if (since_req >= SETTLE && outcome_q.size() == 0) begin
							cfg_bus.data <= stim_q[0].nodes;
							nxt_cfg = 1'b1;
							void'(stim_q.pop_front());
						end
					end else begin
						req_bus.data <= stim_q[0].item;
						nxt_req = 1'b1;
						void'(stim_q.pop_front());
						if (!calm && $urandom_range(0, 3) == 0)
							gap_left = $urandom_range(1, 3);
					end
				end else begin
					stim_done = 1'b1;
				end
			end
			calm <= (stim_q.size() < CALM_TAIL);
			req_bus.valid <= nxt_req;
			cfg_bus.valid <= nxt_cfg;
		end
	end

	// Long receiver hold-off: count cycles once a fair share of transfers has gone in
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_bus.valid && req_bus.ready)
				hold_seen <= hold_seen + 1;
			if (hold_left > 0)
				hold_left <= hold_left - 1;
			else if (!hold_done && hold_seen >= HOLD_AT) begin
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end
		end
	end

	// Receiver: the long hold-off, and short random stalls but none in the tail of the run
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				rsp_bus.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_bus.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 2);
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= 1'b1;
			end
		end
	end

	// Monitor: advance the shadow state on each transfer and check results
	always @(posedge clk) begin
		if (!arst_n) begin
			cluster_nodes = qrat_pkg::NODE_COUNT_RST;
			arrival_q.delete();
			foreach (slot_live[i])
				slot_live[i] = 1'b0;
		end else begin
			if (cfg_bus.valid && cfg_bus.ready)
				cluster_nodes = cfg_bus.data;
			if (req_bus.valid && req_bus.ready)
				predict_read_outcomes(req_bus.data);
			if (rsp_bus.valid && rsp_bus.ready)
				compare_outcome(rsp_bus.data);
		end
	end

endmodule
